// ===== sv/w3ud_pkg.sv =====
`timescale 1ns / 1ps

package w3ud_pkg;

	// Configuration register indexes
	localparam logic [0:0] REG_SPLIT_FLUX_MODE = 1'd0;
	localparam logic [0:0] REG_SMALL_EPS       = 1'd1;

	localparam logic [15:0] EPS_RESET = 16'd43;
	localparam int QUEUE_DEPTH_DEF = 4;

	// Velocity of +1/2 in Q16.16
	localparam logic signed [31:0] HALF_VEL = 32'sd32768;

	// Datapath widths
	localparam int SW    = 34;   // shifted stencil sample
	localparam int DW    = 36;   // second difference
	localparam int AW    = 35;   // magnitude of a second difference
	localparam int TW    = 37;   // third difference
	localparam int TAW   = 36;   // magnitude of a third difference
	localparam int PMW   = 36;   // central difference
	localparam int HHW   = 34;
	localparam int HLW   = 35;
	localparam int LLW   = 36;
	localparam int SQW   = 71;   // square plus epsilon
	localparam int NW    = 30;   // normalised term
	localparam int N2W   = 60;
	localparam int SUMW  = 62;
	localparam int REMW  = 63;
	localparam int QW    = 32;
	localparam int DIVST = 16;   // divider stages
	localparam int DIVBITS = QW / DIVST;
	localparam int TSPLIT = 18;
	localparam int MW1   = 50;
	localparam int W1W   = 68;
	localparam int DDW   = 38;
	localparam int ADW   = 37;
	localparam int VSPLIT = 19;
	localparam int VP0W  = 51;
	localparam int VP1W  = 50;
	localparam int VPW   = 69;
	localparam int TERMW = 54;
	localparam int LANE_LAT = 11 + DIVST;

	localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] SAT_MIN = 32'h8000_0000;

	typedef struct packed {
		logic signed [31:0] v;
		logic signed [31:0] mm;
		logic signed [31:0] m;
		logic signed [31:0] c;
		logic signed [31:0] p;
		logic signed [31:0] pp;
		logic [31:0]        mx;
		logic               split;
	} entry_t;

	typedef struct packed {
		logic signed [31:0]   v;
		logic signed [SW-1:0] mm;
		logic signed [SW-1:0] m;
		logic signed [SW-1:0] c;
		logic signed [SW-1:0] p;
		logic signed [SW-1:0] pp;
		logic                 left;
	} lane_in_t;

	typedef struct packed {
		logic [TAW-1:0]        at;
		logic                  tneg;
		logic signed [PMW-1:0] pm;
		logic signed [31:0]    v;
	} ctx_t;

endpackage

// ===== sv/w3ud_front.sv =====
`timescale 1ns / 1ps

module w3ud_front (
	input  logic               in_valid,
	input  logic               full,
	input  logic               split_flux_mode,
	input  logic signed [31:0] velocity,
	input  logic signed [31:0] sample_mm,
	input  logic signed [31:0] sample_m,
	input  logic signed [31:0] sample_c,
	input  logic signed [31:0] sample_p,
	input  logic signed [31:0] sample_pp,
	output logic               in_stall,
	output logic               push,
	output w3ud_pkg::entry_t   entry
);

	logic [31:0] a_mm, a_m, a_c, a_p, a_pp;
	logic [31:0] mx_a, mx_b, mx_c;

	assign a_mm = sample_mm[31] ? 32'(-sample_mm) : 32'(sample_mm);
	assign a_m  = sample_m[31]  ? 32'(-sample_m)  : 32'(sample_m);
	assign a_c  = sample_c[31]  ? 32'(-sample_c)  : 32'(sample_c);
	assign a_p  = sample_p[31]  ? 32'(-sample_p)  : 32'(sample_p);
	assign a_pp = sample_pp[31] ? 32'(-sample_pp) : 32'(sample_pp);

	// Largest magnitude over the stencil, for split-flux shifting
	assign mx_a = (a_mm > a_m) ? a_mm : a_m;
	assign mx_b = (a_c > a_p) ? a_c : a_p;
	assign mx_c = (mx_a > mx_b) ? mx_a : mx_b;

	always_comb begin
		entry.v     = velocity;
		entry.mm    = sample_mm;
		entry.m     = sample_m;
		entry.c     = sample_c;
		entry.p     = sample_p;
		entry.pp    = sample_pp;
		entry.mx    = (mx_c > a_pp) ? mx_c : a_pp;
		entry.split = split_flux_mode;
	end

	assign in_stall = full;
	assign push     = in_valid && !full;

endmodule

// ===== sv/w3ud_queue.sv =====
`timescale 1ns / 1ps

module w3ud_queue #(
	parameter int DEPTH = w3ud_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  w3ud_pkg::entry_t wdata,
	input  logic             pop,
	output logic             full,
	output logic             empty,
	output w3ud_pkg::entry_t head
);

	localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	w3ud_pkg::entry_t mem_q [DEPTH];
	logic [PTRW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0] cnt_q;
	logic do_push, do_pop;

	assign full    = (cnt_q == CNTW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/w3ud_lane.sv =====
`timescale 1ns / 1ps

module w3ud_lane (
	input  logic                                clk,
	input  logic                                en,
	input  logic [15:0]                         eps,
	input  w3ud_pkg::lane_in_t                  li,
	output logic signed [w3ud_pkg::TERMW-1:0]   term
);

	localparam int DW    = w3ud_pkg::DW;
	localparam int AW    = w3ud_pkg::AW;
	localparam int TW    = w3ud_pkg::TW;
	localparam int TAW   = w3ud_pkg::TAW;
	localparam int PMW   = w3ud_pkg::PMW;
	localparam int HHW   = w3ud_pkg::HHW;
	localparam int HLW   = w3ud_pkg::HLW;
	localparam int LLW   = w3ud_pkg::LLW;
	localparam int SQW   = w3ud_pkg::SQW;
	localparam int NW    = w3ud_pkg::NW;
	localparam int N2W   = w3ud_pkg::N2W;
	localparam int SUMW  = w3ud_pkg::SUMW;
	localparam int REMW  = w3ud_pkg::REMW;
	localparam int QW    = w3ud_pkg::QW;
	localparam int DIVST = w3ud_pkg::DIVST;
	localparam int DIVBITS = w3ud_pkg::DIVBITS;
	localparam int TSPLIT = w3ud_pkg::TSPLIT;
	localparam int MW1   = w3ud_pkg::MW1;
	localparam int W1W   = w3ud_pkg::W1W;
	localparam int DDW   = w3ud_pkg::DDW;
	localparam int ADW   = w3ud_pkg::ADW;
	localparam int VSPLIT = w3ud_pkg::VSPLIT;
	localparam int VP0W  = w3ud_pkg::VP0W;
	localparam int VP1W  = w3ud_pkg::VP1W;
	localparam int VPW   = w3ud_pkg::VPW;
	localparam int TERMW = w3ud_pkg::TERMW;

	// ---- stage 1: differences
	logic signed [DW-1:0]  dc, dn;
	logic signed [TW-1:0]  t;
	logic [AW-1:0]         adc_s1, adn_s1;
	w3ud_pkg::ctx_t        ctx_s1;

	always_comb begin
		dc = DW'(li.p) - (DW'(li.c) <<< 1) + DW'(li.m);
		if (li.left) begin
			dn = DW'(li.c) - (DW'(li.m) <<< 1) + DW'(li.mm);
			t  = TW'(li.p) - TW'(li.mm) + (TW'(li.m) <<< 1) + TW'(li.m)
				- (TW'(li.c) <<< 1) - TW'(li.c);
		end else begin
			dn = DW'(li.pp) - (DW'(li.p) <<< 1) + DW'(li.c);
			t  = TW'(li.pp) - TW'(li.m) + (TW'(li.c) <<< 1) + TW'(li.c)
				- (TW'(li.p) <<< 1) - TW'(li.p);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			adc_s1      <= dc[DW-1] ? AW'(-dc) : AW'(dc);
			adn_s1      <= dn[DW-1] ? AW'(-dn) : AW'(dn);
			ctx_s1.at   <= t[TW-1] ? TAW'(-t) : TAW'(t);
			ctx_s1.tneg <= t[TW-1];
			ctx_s1.pm   <= PMW'(li.p) - PMW'(li.m);
			ctx_s1.v    <= li.v;
		end
	end

	// ---- stage 2: partial products of the squares
	logic [HHW-1:0] hhn_s2, hhd_s2;
	logic [HLW-1:0] hln_s2, hld_s2;
	logic [LLW-1:0] lln_s2, lld_s2;
	w3ud_pkg::ctx_t ctx_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			hhn_s2 <= HHW'(adn_s1[AW-1:TSPLIT]) * HHW'(adn_s1[AW-1:TSPLIT]);
			hln_s2 <= HLW'(adn_s1[AW-1:TSPLIT]) * HLW'(adn_s1[TSPLIT-1:0]);
			lln_s2 <= LLW'(adn_s1[TSPLIT-1:0]) * LLW'(adn_s1[TSPLIT-1:0]);
			hhd_s2 <= HHW'(adc_s1[AW-1:TSPLIT]) * HHW'(adc_s1[AW-1:TSPLIT]);
			hld_s2 <= HLW'(adc_s1[AW-1:TSPLIT]) * HLW'(adc_s1[TSPLIT-1:0]);
			lld_s2 <= LLW'(adc_s1[TSPLIT-1:0]) * LLW'(adc_s1[TSPLIT-1:0]);
			ctx_s2 <= ctx_s1;
		end
	end

	// ---- stage 3: assemble squares and add epsilon
	logic [SQW-1:0] n_s3, d_s3;
	w3ud_pkg::ctx_t ctx_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			n_s3 <= (SQW'(hhn_s2) << (2 * TSPLIT)) + (SQW'(hln_s2) << (TSPLIT + 1))
				+ SQW'(lln_s2) + SQW'(eps);
			d_s3 <= (SQW'(hhd_s2) << (2 * TSPLIT)) + (SQW'(hld_s2) << (TSPLIT + 1))
				+ SQW'(lld_s2) + SQW'(eps);
			ctx_s3 <= ctx_s2;
		end
	end

	// ---- stages 4 and 5: joint normalisation below 2^NW, binary shift steps
	logic [SQW-1:0] na, da, nb, db;
	logic [SQW-1:0] n_s4, d_s4;
	logic [NW-1:0]  n_s5, d_s5;
	w3ud_pkg::ctx_t ctx_s4, ctx_s5;

	always_comb begin
		na = n_s3;
		da = d_s3;
		for (int i = 0; i < 3; i++) begin
			if (((na | da) >> (NW - 1 + (32 >> i))) != '0) begin
				na = na >> (32 >> i);
				da = da >> (32 >> i);
			end
		end
	end

	always_comb begin
		nb = n_s4;
		db = d_s4;
		for (int i = 0; i < 3; i++) begin
			if (((nb | db) >> (NW - 1 + (4 >> i))) != '0) begin
				nb = nb >> (4 >> i);
				db = db >> (4 >> i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s4   <= na;
			d_s4   <= da;
			ctx_s4 <= ctx_s3;
			n_s5   <= nb[NW-1:0];
			d_s5   <= db[NW-1:0];
			ctx_s5 <= ctx_s4;
		end
	end

	// ---- stage 6: squares of the normalised terms
	logic [N2W-1:0] n2_s6, d2_s6;
	w3ud_pkg::ctx_t ctx_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			n2_s6  <= N2W'(n_s5) * N2W'(n_s5);
			d2_s6  <= N2W'(d_s5) * N2W'(d_s5);
			ctx_s6 <= ctx_s5;
		end
	end

	// ---- stage 7 and divider: w = d2 * 2^32 / (d2 + 2*n2)
	logic [SUMW-1:0] dsum_s [DIVST+1];
	logic [REMW-1:0] drem_s [DIVST+1];
	logic [QW-1:0]   dq_s   [DIVST+1];
	logic            dspec_s [DIVST+1];
	w3ud_pkg::ctx_t  dctx_s [DIVST+1];

	always_ff @(posedge clk) begin
		if (en) begin
			dsum_s[0]  <= SUMW'(d2_s6) + (SUMW'(n2_s6) << 1);
			drem_s[0]  <= REMW'(d2_s6);
			dq_s[0]    <= '0;
			// weight is exactly one when the numerator term vanishes
			dspec_s[0] <= (n2_s6 == '0);
			dctx_s[0]  <= ctx_s6;
		end
	end

	for (genvar g = 0; g < DIVST; g++) begin : g_div
		logic [REMW-1:0] r, r2;
		logic [QW-1:0]   q;

		always_comb begin
			r  = drem_s[g];
			q  = dq_s[g];
			r2 = '0;
			for (int k = 0; k < DIVBITS; k++) begin
				r2 = {r[REMW-2:0], 1'b0};
				if (r2 >= REMW'(dsum_s[g])) begin
					r = r2 - REMW'(dsum_s[g]);
					q = {q[QW-2:0], 1'b1};
				end else begin
					r = r2;
					q = {q[QW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dsum_s[g+1]  <= dsum_s[g];
				drem_s[g+1]  <= r;
				dq_s[g+1]    <= q;
				dspec_s[g+1] <= dspec_s[g];
				dctx_s[g+1]  <= dctx_s[g];
			end
		end
	end

	// ---- stages W1, W2: w * |T| rounded, then blend
	logic [MW1-1:0]  wp0_s8, wp1_s8;
	logic            spec_s8;
	w3ud_pkg::ctx_t  ctx_s8;
	logic [W1W-1:0]  wprod;
	logic [TAW-1:0]  mt;
	logic signed [DDW-1:0] pmx, mtx, dd;
	logic [ADW-1:0]  ad_s9;
	logic [31:0]     av_s9;
	logic            neg_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			wp0_s8  <= MW1'(dq_s[DIVST]) * MW1'(dctx_s[DIVST].at[TSPLIT-1:0]);
			wp1_s8  <= MW1'(dq_s[DIVST]) * MW1'(dctx_s[DIVST].at[TAW-1:TSPLIT]);
			spec_s8 <= dspec_s[DIVST];
			ctx_s8  <= dctx_s[DIVST];
		end
	end

	always_comb begin
		wprod = (W1W'(wp1_s8) << TSPLIT) + W1W'(wp0_s8) + (W1W'(1) << (QW - 1));
		mt    = spec_s8 ? ctx_s8.at : wprod[W1W-1 -: TAW];
		pmx   = DDW'(ctx_s8.pm);
		mtx   = signed'(DDW'(mt));
		dd    = ctx_s8.tneg ? pmx + mtx : pmx - mtx;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ad_s9  <= dd[DDW-1] ? ADW'(-dd) : ADW'(dd);
			av_s9  <= ctx_s8.v[31] ? 32'(-ctx_s8.v) : 32'(ctx_s8.v);
			neg_s9 <= ctx_s8.v[31] != dd[DDW-1];
		end
	end

	// ---- stages V1, V2: v * D rounded to Q16.16
	logic [VP0W-1:0] vp0_s10;
	logic [VP1W-1:0] vp1_s10;
	logic            neg_s10;
	logic [VPW-1:0]  vprod;

	always_ff @(posedge clk) begin
		if (en) begin
			vp0_s10 <= VP0W'(av_s9) * VP0W'(ad_s9[VSPLIT-1:0]);
			vp1_s10 <= VP1W'(av_s9) * VP1W'(ad_s9[ADW-1:VSPLIT]);
			neg_s10 <= neg_s9;
		end
	end

	assign vprod = (VPW'(vp1_s10) << VSPLIT) + VPW'(vp0_s10) + (VPW'(1) << 16);

	always_ff @(posedge clk) begin
		if (en) begin
			term <= neg_s10 ? -signed'(TERMW'(vprod[VPW-1:17]))
				: signed'(TERMW'(vprod[VPW-1:17]));
		end
	end

endmodule

// ===== sv/w3ud_back.sv =====
`timescale 1ns / 1ps

module w3ud_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [15:0]        small_eps,
	input  logic               q_empty,
	input  w3ud_pkg::entry_t   head,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] derivative,
	output logic               overflowed
);

	localparam int SW    = w3ud_pkg::SW;
	localparam int TERMW = w3ud_pkg::TERMW;
	localparam int NSTG  = w3ud_pkg::LANE_LAT + 1;
	localparam int RW    = TERMW + 1;

	logic adv;
	logic [NSTG-1:0] vld_q;
	w3ud_pkg::lane_in_t la_s0, lb_s0;
	logic signed [TERMW-1:0] term_a, term_b;
	logic signed [RW-1:0] res;
	logic out_valid_q, overflowed_q;
	logic signed [31:0] derivative_q;

	// The whole back end freezes while a finished result is held
	assign adv   = !out_valid_q || !out_stall;
	assign q_pop = adv;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (head.split) begin
				la_s0.v    <= w3ud_pkg::HALF_VEL;
				la_s0.mm   <= SW'(head.mm) + signed'(SW'(head.mx));
				la_s0.m    <= SW'(head.m) + signed'(SW'(head.mx));
				la_s0.c    <= SW'(head.c) + signed'(SW'(head.mx));
				la_s0.p    <= SW'(head.p) + signed'(SW'(head.mx));
				la_s0.pp   <= SW'(head.pp) + signed'(SW'(head.mx));
				la_s0.left <= 1'b1;
				lb_s0.v    <= -w3ud_pkg::HALF_VEL;
				lb_s0.mm   <= signed'(SW'(head.mx)) - SW'(head.mm);
				lb_s0.m    <= signed'(SW'(head.mx)) - SW'(head.m);
				lb_s0.c    <= signed'(SW'(head.mx)) - SW'(head.c);
				lb_s0.p    <= signed'(SW'(head.mx)) - SW'(head.p);
				lb_s0.pp   <= signed'(SW'(head.mx)) - SW'(head.pp);
				lb_s0.left <= 1'b0;
			end else begin
				la_s0.v    <= head.v;
				la_s0.mm   <= SW'(head.mm);
				la_s0.m    <= SW'(head.m);
				la_s0.c    <= SW'(head.c);
				la_s0.p    <= SW'(head.p);
				la_s0.pp   <= SW'(head.pp);
				la_s0.left <= !head.v[31] && (head.v != '0);
				// zero velocity: this lane contributes nothing
				lb_s0.v    <= '0;
				lb_s0.mm   <= SW'(head.mm);
				lb_s0.m    <= SW'(head.m);
				lb_s0.c    <= SW'(head.c);
				lb_s0.p    <= SW'(head.p);
				lb_s0.pp   <= SW'(head.pp);
				lb_s0.left <= 1'b0;
			end
		end
	end

	w3ud_lane u_lane_a (
		.clk  (clk),
		.en   (adv),
		.eps  (small_eps),
		.li   (la_s0),
		.term (term_a)
	);

	w3ud_lane u_lane_b (
		.clk  (clk),
		.en   (adv),
		.eps  (small_eps),
		.li   (lb_s0),
		.term (term_b)
	);

	assign res = RW'(term_a) + RW'(term_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_q       <= {vld_q[NSTG-2:0], !q_empty};
			out_valid_q <= vld_q[NSTG-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (res[RW-1:31] == '0 || res[RW-1:31] == '1) begin
				derivative_q <= res[31:0];
				overflowed_q <= 1'b0;
			end else if (res[RW-1]) begin
				derivative_q <= w3ud_pkg::SAT_MIN;
				overflowed_q <= 1'b1;
			end else begin
				derivative_q <= w3ud_pkg::SAT_MAX;
				overflowed_q <= 1'b1;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign derivative = derivative_q;
	assign overflowed = overflowed_q;

`ifndef SYNTH
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q))
		else $error("pipeline valid bits moved while frozen");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld_q[0] |=> vld_q[1])
		else $error("transaction lost between back stages");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && overflowed_q |->
		(derivative_q == w3ud_pkg::SAT_MAX || derivative_q == w3ud_pkg::SAT_MIN))
		else $error("overflow flagged on unsaturated result");
`endif

endmodule

// ===== sv/weno3_upwind_derivative_top.sv =====
`timescale 1ns / 1ps

// channel   dir  handshake              payload
// input     in   in_valid / in_stall    velocity, sample_mm, sample_m, sample_c,
//                                       sample_p, sample_pp
// output    out  out_valid / out_stall  derivative, overflowed
// config    in   cfg_we                 cfg_index, cfg_data
//
// One transaction per cycle sustained while out_stall is low; both WENO lanes are
// fully pipelined. Latency is set mostly by the 16-stage radix-4 weight divider
// in each lane.
// Reset clears the queue, all valid bits and restores the register defaults.
// out_stall freezes the whole back end while out_valid is high; the queue keeps
// taking transactions until it fills, then in_stall rises.

module weno3_upwind_derivative_top #(
	parameter int QUEUE_DEPTH = w3ud_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] velocity,
	input  logic signed [31:0] sample_mm,
	input  logic signed [31:0] sample_m,
	input  logic signed [31:0] sample_c,
	input  logic signed [31:0] sample_p,
	input  logic signed [31:0] sample_pp,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] derivative,
	output logic               overflowed,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	logic split_flux_mode_q;
	logic [15:0] small_eps_q;
	logic push, full, empty, pop;
	w3ud_pkg::entry_t entry, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_flux_mode_q <= 1'b0;
			small_eps_q       <= w3ud_pkg::EPS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				w3ud_pkg::REG_SPLIT_FLUX_MODE: split_flux_mode_q <= cfg_data[0];
				w3ud_pkg::REG_SMALL_EPS:       small_eps_q <= cfg_data;
				default: ;
			endcase
		end
	end

	w3ud_front u_front (
		.in_valid        (in_valid),
		.full            (full),
		.split_flux_mode (split_flux_mode_q),
		.velocity        (velocity),
		.sample_mm       (sample_mm),
		.sample_m        (sample_m),
		.sample_c        (sample_c),
		.sample_p        (sample_p),
		.sample_pp       (sample_pp),
		.in_stall        (in_stall),
		.push            (push),
		.entry           (entry)
	);

	w3ud_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (entry),
		.pop    (pop),
		.full   (full),
		.empty  (empty),
		.head   (head)
	);

	w3ud_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.small_eps  (small_eps_q),
		.q_empty    (empty),
		.head       (head),
		.q_pop      (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.derivative (derivative),
		.overflowed (overflowed)
	);

endmodule
